/* rtl/core/pfe_pkg.sv */
// Shared types and constants of the postfix expression evaluator.
// Used by pfe_ctrl, pfe_dpath, pfe_div and postfix_expression_evaluator.
// Depends on nothing.
`default_nettype none

package pfe_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DATA_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int ERR_W       = 2;
    localparam int CNT_W       = $clog2(DATA_W);
    localparam int OUT_TDATA_W = ((DATA_W + ERR_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - ERR_W;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_TIMES = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [3:0]        RADIX    = 4'd10;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2,
        ERR_DIVZ  = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_NORMAL,
        S_TAIL,
        S_POPB,
        S_LDB,
        S_POPA,
        S_LDA,
        S_EXEC,
        S_DIVW,
        S_PUSH,
        S_END_POP,
        S_END_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic clr_pending;
        logic set_pending;
        logic num_start_neg;
        logic num_start_pos;
        logic num_accum;
        logic push_num;
        logic op_from_char;
        logic op_minus;
        logic pop;
        logic load_b;
        logic load_a;
        logic exec;
        logic div_load;
        logic push_res;
        logic end_load;
        logic clear_ctl;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_digit;
        logic is_minus;
        logic is_op;
        logic pending;
        logic in_number;
        logic last;
        logic div_run;
        logic div_done;
        logic out_full;
    } t_status;

endpackage

`default_nettype wire

/* rtl/core/pfe_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pfe_pkg.
`default_nettype none

module pfe_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [pfe_pkg::DATA_W-1:0] i_dividend,
    input  wire logic [pfe_pkg::DATA_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [pfe_pkg::DATA_W-1:0]      o_quotient
);

    logic                         r_busy;
    logic                         r_done;
    logic [pfe_pkg::CNT_W-1:0]    r_cnt;
    logic [pfe_pkg::DATA_W-1:0]   r_rem;
    logic [pfe_pkg::DATA_W-1:0]   r_quo;
    logic [pfe_pkg::DATA_W-1:0]   r_dvs;
    logic                         r_neg;
    logic [pfe_pkg::DATA_W-1:0]   r_result;

    logic [pfe_pkg::DATA_W-1:0]   mag_a;
    logic [pfe_pkg::DATA_W-1:0]   mag_b;
    logic [pfe_pkg::DATA_W:0]     rem_sh;
    logic [pfe_pkg::DATA_W:0]     diff;
    logic [pfe_pkg::DATA_W-1:0]   n_rem;
    logic [pfe_pkg::DATA_W-1:0]   n_quo;
    logic                         last_step;

    always_comb begin
        mag_a  = i_dividend[pfe_pkg::DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
        mag_b  = i_divisor[pfe_pkg::DATA_W-1] ? (~i_divisor + 1'b1) : i_divisor;
        rem_sh = {r_rem, r_quo[pfe_pkg::DATA_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        if (!diff[pfe_pkg::DATA_W]) begin
            n_rem = diff[pfe_pkg::DATA_W-1:0];
            n_quo = {r_quo[pfe_pkg::DATA_W-2:0], 1'b1};
        end else begin
            n_rem = rem_sh[pfe_pkg::DATA_W-1:0];
            n_quo = {r_quo[pfe_pkg::DATA_W-2:0], 1'b0};
        end
        last_step = (r_cnt == pfe_pkg::CNT_W'(pfe_pkg::DATA_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag_a;
            r_dvs <= mag_b;
            r_neg <= i_dividend[pfe_pkg::DATA_W-1] ^ i_divisor[pfe_pkg::DATA_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            if (last_step) begin
                r_result <= r_neg ? (~n_quo + 1'b1) : n_quo;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_result;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done lasted more than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy) && !r_busy)
        else $error("divider finished without running");

endmodule

`default_nettype wire

/* rtl/core/pfe_dpath.sv */
// Datapath: character register, number builder, operand stack memory,
// arithmetic unit with the divider, error tracking and the result register.
// Depends on pfe_pkg and pfe_div.
`default_nettype none

module pfe_dpath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [pfe_pkg::CHAR_W-1:0] i_char,
    input  wire logic                       i_last,
    input  wire pfe_pkg::t_cmd              i_cmd,
    output pfe_pkg::t_status                o_status,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic [pfe_pkg::DATA_W-1:0]      o_value,
    output logic [pfe_pkg::ERR_W-1:0]       o_err
);

    logic [pfe_pkg::DATA_W-1:0] r_mem [pfe_pkg::STACK_DEPTH];
    logic [pfe_pkg::DATA_W-1:0] r_rdata;

    logic [pfe_pkg::CHAR_W-1:0] r_char;
    logic                       r_last;
    logic [pfe_pkg::SP_W-1:0]   r_sp;
    logic [pfe_pkg::DATA_W-1:0] r_acc;
    logic                       r_in_number;
    logic                       r_neg;
    logic                       r_pending;
    pfe_pkg::t_err              r_sticky;
    pfe_pkg::t_op               r_op;
    logic                       r_pop_empty;
    logic [pfe_pkg::DATA_W-1:0] r_a;
    logic [pfe_pkg::DATA_W-1:0] r_b;
    logic [pfe_pkg::DATA_W-1:0] r_res;
    logic                       r_out_valid;
    logic [pfe_pkg::DATA_W-1:0] r_out_value;
    pfe_pkg::t_err              r_out_err;

    logic                       is_digit;
    logic [pfe_pkg::DATA_W-1:0] digit_val;
    pfe_pkg::t_op               char_op;
    logic                       sp_zero;
    logic                       sp_full;
    logic                       b_zero;
    logic                       div_start;
    logic                       div_done;
    logic [pfe_pkg::DATA_W-1:0] div_quo;
    logic [pfe_pkg::DATA_W-1:0] num_val;
    logic [pfe_pkg::DATA_W-1:0] wr_data;
    logic                       wr_en;
    logic                       rd_en;
    logic [pfe_pkg::ADDR_W-1:0] rd_addr;
    logic [pfe_pkg::SP_W-1:0]   sp_dec;
    pfe_pkg::t_err              n_flag;

    always_comb begin
        is_digit  = (r_char >= pfe_pkg::CH_ZERO) && (r_char <= pfe_pkg::CH_NINE);
        digit_val = pfe_pkg::DATA_W'(r_char[3:0]);
        unique case (r_char)
            pfe_pkg::CH_PLUS:  char_op = pfe_pkg::OP_ADD;
            pfe_pkg::CH_TIMES: char_op = pfe_pkg::OP_MUL;
            pfe_pkg::CH_DIV:   char_op = pfe_pkg::OP_DIV;
            default:           char_op = pfe_pkg::OP_SUB;
        endcase
        sp_zero   = (r_sp == '0);
        sp_full   = (r_sp >= pfe_pkg::SP_W'(pfe_pkg::STACK_DEPTH));
        sp_dec    = r_sp - 1'b1;
        rd_addr   = sp_dec[pfe_pkg::ADDR_W-1:0];
        rd_en     = i_cmd.pop && !sp_zero;
        b_zero    = (r_b == '0);
        num_val   = r_neg ? (~r_acc + 1'b1) : r_acc;
        wr_data   = i_cmd.push_num ? num_val : r_res;
        wr_en     = (i_cmd.push_num || i_cmd.push_res) && !sp_full;
        div_start = i_cmd.exec && (r_op == pfe_pkg::OP_DIV) && !b_zero;

        n_flag = pfe_pkg::ERR_NONE;
        if (i_cmd.pop && sp_zero) begin
            n_flag = pfe_pkg::ERR_UNDER;
        end else if (i_cmd.exec && (r_op == pfe_pkg::OP_DIV) && b_zero) begin
            n_flag = pfe_pkg::ERR_DIVZ;
        end else if ((i_cmd.push_num || i_cmd.push_res) && sp_full) begin
            n_flag = pfe_pkg::ERR_OVER;
        end
    end

    // The stack memory: one write port at the pointer, one registered read below it.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_sp[pfe_pkg::ADDR_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_acc       <= '0;
            r_in_number <= 1'b0;
            r_neg       <= 1'b0;
            r_pending   <= 1'b0;
            r_sticky    <= pfe_pkg::ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_pending) begin
                r_pending <= 1'b0;
            end
            if (i_cmd.set_pending) begin
                r_pending <= 1'b1;
            end
            if (i_cmd.num_start_neg || i_cmd.num_start_pos) begin
                r_in_number <= 1'b1;
                r_neg       <= i_cmd.num_start_neg;
                r_acc       <= digit_val;
            end
            if (i_cmd.num_accum) begin
                r_acc <= (r_acc << 3) + (r_acc << 1) + digit_val;
            end
            if (i_cmd.push_num) begin
                r_in_number <= 1'b0;
                r_neg       <= 1'b0;
                r_acc       <= '0;
            end
            if (rd_en) begin
                r_sp <= sp_dec;
            end
            if (wr_en) begin
                r_sp <= r_sp + 1'b1;
            end
            if ((r_sticky == pfe_pkg::ERR_NONE) && (n_flag != pfe_pkg::ERR_NONE)) begin
                r_sticky <= n_flag;
            end
            if (i_cmd.end_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear_ctl) begin
                r_sp        <= '0;
                r_acc       <= '0;
                r_in_number <= 1'b0;
                r_neg       <= 1'b0;
                r_pending   <= 1'b0;
                r_sticky    <= pfe_pkg::ERR_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_char <= i_char;
            r_last <= i_last;
        end
        if (i_cmd.op_from_char) begin
            r_op <= char_op;
        end
        if (i_cmd.op_minus) begin
            r_op <= pfe_pkg::OP_SUB;
        end
        if (i_cmd.pop) begin
            r_pop_empty <= sp_zero;
        end
        if (i_cmd.load_b) begin
            r_b <= r_pop_empty ? '0 : r_rdata;
        end
        if (i_cmd.load_a) begin
            r_a <= r_pop_empty ? '0 : r_rdata;
        end
        if (i_cmd.exec) begin
            unique case (r_op)
                pfe_pkg::OP_ADD: r_res <= r_a + r_b;
                pfe_pkg::OP_SUB: r_res <= r_a - r_b;
                pfe_pkg::OP_MUL: r_res <= r_a * r_b;
                pfe_pkg::OP_DIV: r_res <= '0;
                default:         r_res <= '0;
            endcase
        end
        if (i_cmd.div_load) begin
            r_res <= div_quo;
        end
        if (i_cmd.end_load) begin
            r_out_value <= r_pop_empty ? '0 : r_rdata;
            r_out_err   <= r_sticky;
        end
    end

    pfe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        o_status.is_digit  = is_digit;
        o_status.is_minus  = (r_char == pfe_pkg::CH_MINUS);
        o_status.is_op     = (r_char == pfe_pkg::CH_PLUS) || (r_char == pfe_pkg::CH_TIMES)
                             || (r_char == pfe_pkg::CH_DIV);
        o_status.pending   = r_pending;
        o_status.in_number = r_in_number;
        o_status.last      = r_last;
        o_status.div_run   = (r_op == pfe_pkg::OP_DIV) && !b_zero;
        o_status.div_done  = div_done;
        o_status.out_full  = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_err       = r_out_err;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= pfe_pkg::SP_W'(pfe_pkg::STACK_DEPTH))
        else $error("stack pointer beyond the stack depth");

endmodule

`default_nettype wire

/* rtl/core/pfe_ctrl.sv */
// Controller: sequences the handling of one character as datapath commands.
// Depends on pfe_pkg.
`default_nettype none

module pfe_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire pfe_pkg::t_status i_status,
    output pfe_pkg::t_cmd         o_cmd
);

    pfe_pkg::t_state r_state;
    pfe_pkg::t_state n_state;
    pfe_pkg::t_state r_ret;
    pfe_pkg::t_state n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfe_pkg::S_IDLE;
            r_ret   <= pfe_pkg::S_TAIL;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            pfe_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = pfe_pkg::S_DECODE;
                end
            end
            // A held minus is settled by the character that follows it.
            pfe_pkg::S_DECODE: begin
                if (i_status.pending) begin
                    o_cmd.clr_pending = 1'b1;
                    if (i_status.is_digit) begin
                        o_cmd.num_start_neg = 1'b1;
                        n_state             = pfe_pkg::S_TAIL;
                    end else begin
                        o_cmd.op_minus = 1'b1;
                        n_ret          = pfe_pkg::S_NORMAL;
                        n_state        = pfe_pkg::S_POPB;
                    end
                end else begin
                    n_state = pfe_pkg::S_NORMAL;
                end
            end
            pfe_pkg::S_NORMAL: begin
                if (i_status.in_number) begin
                    if (i_status.is_digit) begin
                        o_cmd.num_accum = 1'b1;
                        n_state         = pfe_pkg::S_TAIL;
                    end else begin
                        // Close the number, then look at the character again.
                        o_cmd.push_num = 1'b1;
                    end
                end else if (i_status.is_digit) begin
                    o_cmd.num_start_pos = 1'b1;
                    n_state             = pfe_pkg::S_TAIL;
                end else if (i_status.is_minus) begin
                    o_cmd.set_pending = 1'b1;
                    n_state           = pfe_pkg::S_TAIL;
                end else if (i_status.is_op) begin
                    o_cmd.op_from_char = 1'b1;
                    n_ret              = pfe_pkg::S_TAIL;
                    n_state            = pfe_pkg::S_POPB;
                end else begin
                    n_state = pfe_pkg::S_TAIL;
                end
            end
            pfe_pkg::S_TAIL: begin
                if (!i_status.last) begin
                    n_state = pfe_pkg::S_IDLE;
                end else if (i_status.pending) begin
                    o_cmd.clr_pending = 1'b1;
                    o_cmd.op_minus    = 1'b1;
                    n_ret             = pfe_pkg::S_TAIL;
                    n_state           = pfe_pkg::S_POPB;
                end else if (i_status.in_number) begin
                    o_cmd.push_num = 1'b1;
                end else begin
                    n_state = pfe_pkg::S_END_POP;
                end
            end
            pfe_pkg::S_POPB: begin
                o_cmd.pop = 1'b1;
                n_state   = pfe_pkg::S_LDB;
            end
            pfe_pkg::S_LDB: begin
                o_cmd.load_b = 1'b1;
                n_state      = pfe_pkg::S_POPA;
            end
            pfe_pkg::S_POPA: begin
                o_cmd.pop = 1'b1;
                n_state   = pfe_pkg::S_LDA;
            end
            pfe_pkg::S_LDA: begin
                o_cmd.load_a = 1'b1;
                n_state      = pfe_pkg::S_EXEC;
            end
            pfe_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.div_run ? pfe_pkg::S_DIVW : pfe_pkg::S_PUSH;
            end
            pfe_pkg::S_DIVW: begin
                if (i_status.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = pfe_pkg::S_PUSH;
                end
            end
            pfe_pkg::S_PUSH: begin
                o_cmd.push_res = 1'b1;
                n_state        = r_ret;
            end
            pfe_pkg::S_END_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = pfe_pkg::S_END_OUT;
            end
            pfe_pkg::S_END_OUT: begin
                if (!i_status.out_full) begin
                    o_cmd.end_load  = 1'b1;
                    o_cmd.clear_ctl = 1'b1;
                    n_state         = pfe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfe_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/postfix_expression_evaluator.sv */
// Top level of the postfix expression evaluator.
// Depends on pfe_pkg, pfe_ctrl and pfe_dpath.
//
// Usage: the slave channel carries one ASCII character per transaction, with
// tlast set on the final character of an expression. Digits build numbers,
// spaces separate tokens, a minus directly followed by a digit starts a
// negative number, and + - * / combine the two top operands of a 64-entry
// stack. On the transaction with tlast, one result transaction on the master
// channel gives the top of the stack and an error code (0 ok, 1 underflow,
// 2 overflow, 3 divide by zero, the first error of the expression wins).
// Throughput: characters are handled one at a time; the next transaction is
// accepted only once the current character has been handled. A character
// that closes an open number first pushes the number and is then decoded
// again. An operator pops its two operands, executes and pushes the result;
// a division by a nonzero divisor waits for the 32-step divider, and a held
// minus that becomes a subtraction runs the same steps. The last character
// also closes an open number, applies a held minus and pops the top of the
// stack memory for the result.
// The result sits in an output register, so the next expression can start
// while it waits; if the receiver stalls and another result is due, the
// block holds in place until the register is free. Reset clears the control
// state and the stack pointer; the stack memory is never cleared.
`default_nettype none

module postfix_expression_evaluator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: [7:0] char_code
    input  wire logic [pfe_pkg::CHAR_W-1:0]      i_s_axis_tdata,
    // tlast: last_char
    input  wire logic                            i_s_axis_tlast,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // tdata: [31:0] value, [33:32] error_code, [39:34] zero
    output logic [pfe_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    pfe_pkg::t_cmd              cmd;
    pfe_pkg::t_status           status;
    logic [pfe_pkg::DATA_W-1:0] value;
    logic [pfe_pkg::ERR_W-1:0]  err;

    pfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pfe_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_value     (value),
        .o_err       (err)
    );

    assign o_m_axis_tdata = {{pfe_pkg::OUT_PAD_W{1'b0}}, err, value};

endmodule

`default_nettype wire
